// ===== rtl/dost_pkg.sv =====
// Shared types, codes and constants of the dual output safety timer.
package dost_pkg;

	localparam int unsigned NUM_CH          = 2;
	localparam int unsigned MV_W            = 12;
	localparam int unsigned MS_W            = 32;
	localparam int unsigned CODE_W          = 8;
	localparam int unsigned TEST_MS_DEFAULT = 3000;
	localparam int unsigned LEVEL_MV_DEFAULT = 500;

	localparam logic [MV_W-1:0] REF_RESET_MV = 12'd3300;
	localparam logic [MV_W-1:0] REF_LOW_MV   = 12'd2500;
	localparam logic [MV_W-1:0] REF_HIGH_MV  = 12'd3600;
	localparam logic [CODE_W-1:0] CODE_MAX   = 8'd255;

	// mv*255 + ref/2 stays below 2^20, and below 512*ref for ref >= 2500
	localparam int unsigned NUM_W  = 20;
	localparam int unsigned QBITS  = 9;
	localparam int unsigned CNT_W  = $clog2(QBITS + 1);

	typedef enum logic [3:0] {
		OP_TICK     = 4'd0,
		OP_ENABLE   = 4'd1,
		OP_DISABLE  = 4'd2,
		OP_SET_MV   = 4'd3,
		OP_TEST     = 4'd4,
		OP_TIMEOUT  = 4'd5,
		OP_ALL_ON   = 4'd6,
		OP_ALL_OFF  = 4'd7,
		OP_ALL_TEST = 4'd8,
		OP_DEFAULTS = 4'd9
	} op_t;

	typedef enum logic [1:0] {
		ERR_NONE    = 2'd0,
		ERR_DIGITAL = 2'd1,
		ERR_RANGE   = 2'd2
	} err_t;

	typedef enum logic [1:0] {
		REL_NONE    = 2'd0,
		REL_TEST    = 2'd1,
		REL_TIMEOUT = 2'd2
	} rel_t;

	typedef struct packed {
		logic exec;
		logic div_load;
		logic div_step;
		logic out_load;
	} dost_cmd_t;

	typedef struct packed {
		logic div_done;
	} dost_sts_t;

endpackage

// ===== rtl/dost_if.sv =====
// Command and result channel interfaces.
interface dost_in_if;
	logic        valid;
	logic        ready;
	logic [3:0]  opcode;
	logic        channel;
	logic [31:0] value;

	modport source (output valid, output opcode, output channel, output value, input ready);
	modport sink (input valid, input opcode, input channel, input value, output ready);
endinterface

interface dost_out_if;
	logic       valid;
	logic       ready;
	logic       analog_enable;
	logic [7:0] analog_code;
	logic       digital_high;
	logic [1:0] error_code;
	logic [1:0] analog_release;
	logic [1:0] digital_release;
	logic       timed_active;
	logic       any_active;

	modport source (output valid, output analog_enable, output analog_code,
		output digital_high, output error_code, output analog_release,
		output digital_release, output timed_active, output any_active, input ready);
	modport sink (input valid, input analog_enable, input analog_code,
		input digital_high, input error_code, input analog_release,
		input digital_release, input timed_active, input any_active, output ready);
endinterface

// ===== rtl/dost_dp.sv =====
// Datapath: channel state, command execution, iterative code divider, result register.
module dost_dp #(
	parameter int unsigned TEST_DURATION_MS = dost_pkg::TEST_MS_DEFAULT,
	parameter int unsigned DEFAULT_LEVEL_MV = dost_pkg::LEVEL_MV_DEFAULT
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dost_pkg::dost_cmd_t     cmd,
	output dost_pkg::dost_sts_t     sts,
	input  logic [3:0]              opcode,
	input  logic                    channel,
	input  logic [31:0]             value,
	input  logic                    cfg_we,
	input  logic [11:0]             cfg_wdata,
	output logic                    analog_enable,
	output logic [7:0]              analog_code,
	output logic                    digital_high,
	output logic [1:0]              error_code,
	output logic [1:0]              analog_release,
	output logic [1:0]              digital_release,
	output logic                    timed_active,
	output logic                    any_active
);
	import dost_pkg::*;

	localparam logic [MS_W-1:0] TEST_MS  = MS_W'(TEST_DURATION_MS);
	localparam logic [MV_W-1:0] LEVEL_MV = MV_W'(DEFAULT_LEVEL_MV);
	localparam logic [MS_W-1:0] MS_MAX   = '1;

	logic [NUM_CH-1:0] en_q, en_d, test_q, test_d;
	logic [MS_W-1:0]   el_q [NUM_CH];
	logic [MS_W-1:0]   el_d [NUM_CH];
	logic [MS_W-1:0]   lim_q [NUM_CH];
	logic [MS_W-1:0]   lim_d [NUM_CH];
	logic [MV_W-1:0]   tgt_q, tgt_d, ref_q, ref_d;
	err_t              err_q, err_d;
	rel_t              rel_q [NUM_CH];
	rel_t              rel_d [NUM_CH];

	logic [MS_W-1:0]   inc;
	logic              ch_idx;

	always_comb begin
		en_d   = en_q;
		test_d = test_q;
		el_d   = el_q;
		lim_d  = lim_q;
		tgt_d  = tgt_q;
		ref_d  = ref_q;
		err_d  = err_q;
		rel_d  = rel_q;
		inc    = '0;
		ch_idx = channel;
		if (cmd.exec) begin
			err_d = ERR_NONE;
			for (int i = 0; i < NUM_CH; i++) begin
				rel_d[i] = REL_NONE;
			end
			case (op_t'(opcode))
				OP_TICK: begin
					for (int i = 0; i < NUM_CH; i++) begin
						inc = (en_q[i] && el_q[i] != MS_MAX) ? el_q[i] + 1'b1 : el_q[i];
						el_d[i] = inc;
						if (test_q[i]) begin
							if (inc >= TEST_MS) begin
								rel_d[i] = REL_TEST;
							end
						end else if (en_q[i] && lim_q[i] != '0 && inc >= lim_q[i]) begin
							rel_d[i] = REL_TIMEOUT;
						end
						if (rel_d[i] != REL_NONE) begin
							en_d[i]   = 1'b0;
							test_d[i] = 1'b0;
							el_d[i]   = '0;
						end
					end
				end
				OP_ENABLE, OP_DISABLE: begin
					test_d[ch_idx] = 1'b0;
					en_d[ch_idx]   = (op_t'(opcode) == OP_ENABLE);
					el_d[ch_idx]   = '0;
				end
				OP_SET_MV: begin
					if (channel) begin
						err_d = ERR_DIGITAL;
					end else if (value > {20'd0, ref_q}) begin
						err_d = ERR_RANGE;
					end else begin
						// a running test is cancelled and turns the channel off
						en_d[0]   = en_q[0] && !test_q[0];
						test_d[0] = 1'b0;
						el_d[0]   = '0;
						tgt_d     = value[MV_W-1:0];
					end
				end
				OP_TEST: begin
					en_d[ch_idx]   = 1'b1;
					test_d[ch_idx] = 1'b1;
					el_d[ch_idx]   = '0;
				end
				OP_TIMEOUT: begin
					lim_d[ch_idx] = value;
					if (en_q[ch_idx] && !test_q[ch_idx]) begin
						el_d[ch_idx] = '0;
					end
				end
				OP_ALL_ON, OP_ALL_OFF, OP_ALL_TEST: begin
					for (int i = 0; i < NUM_CH; i++) begin
						en_d[i]   = (op_t'(opcode) != OP_ALL_OFF);
						test_d[i] = (op_t'(opcode) == OP_ALL_TEST);
						el_d[i]   = '0;
					end
				end
				OP_DEFAULTS: begin
					for (int i = 0; i < NUM_CH; i++) begin
						en_d[i]   = 1'b0;
						test_d[i] = 1'b0;
						el_d[i]   = '0;
						lim_d[i]  = '0;
					end
					tgt_d = LEVEL_MV;
					ref_d = REF_RESET_MV;
				end
				default: begin
				end
			endcase
		end else if (cfg_we && cfg_wdata >= REF_LOW_MV && cfg_wdata <= REF_HIGH_MV) begin
			ref_d = cfg_wdata;
			if (tgt_q > cfg_wdata) begin
				tgt_d = cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q   <= '0;
			test_q <= '0;
			for (int i = 0; i < NUM_CH; i++) begin
				el_q[i]  <= '0;
				lim_q[i] <= '0;
				rel_q[i] <= REL_NONE;
			end
			tgt_q <= LEVEL_MV;
			ref_q <= REF_RESET_MV;
			err_q <= ERR_NONE;
		end else begin
			en_q   <= en_d;
			test_q <= test_d;
			el_q   <= el_d;
			lim_q  <= lim_d;
			tgt_q  <= tgt_d;
			ref_q  <= ref_d;
			err_q  <= err_d;
			rel_q  <= rel_d;
		end
	end

	// code = (mv*255 + ref/2) / ref, one quotient bit per cycle
	logic [MV_W-1:0]  mv_sel;
	logic [NUM_W-1:0] num;
	logic [MV_W-1:0]  rem_q;
	logic [QBITS-1:0] lo_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MV_W:0]    trial;
	logic             ge;

	assign mv_sel = test_q[0] ? LEVEL_MV : tgt_q;
	assign num    = (NUM_W'(mv_sel) * NUM_W'(CODE_MAX)) + NUM_W'(ref_q[MV_W-1:1]);
	assign trial  = {rem_q, lo_q[QBITS-1]};
	assign ge     = trial >= {1'b0, ref_q};
	assign sts.div_done = (cnt_q == CNT_W'(QBITS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_load) begin
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			rem_q <= MV_W'(num[NUM_W-1:QBITS]);
			lo_q  <= num[QBITS-1:0];
		end else if (cmd.div_step) begin
			rem_q <= ge ? MV_W'(trial - {1'b0, ref_q}) : trial[MV_W-1:0];
			lo_q  <= {lo_q[QBITS-2:0], ge};
		end
	end

	logic [CODE_W-1:0] code_sat;
	logic              timed, any;

	assign code_sat = !en_q[0] ? '0 :
		(lo_q[QBITS-1:CODE_W] != '0) ? CODE_MAX : lo_q[CODE_W-1:0];

	always_comb begin
		timed = 1'b0;
		any   = 1'b0;
		for (int i = 0; i < NUM_CH; i++) begin
			if (en_q[i]) begin
				any = 1'b1;
				if (test_q[i] || lim_q[i] != '0) begin
					timed = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			analog_enable   <= en_q[0];
			analog_code     <= code_sat;
			digital_high    <= en_q[1];
			error_code      <= err_q;
			analog_release  <= rel_q[0];
			digital_release <= rel_q[1];
			timed_active    <= timed;
			any_active      <= any;
		end
	end

endmodule

// ===== rtl/dost_ctrl.sv =====
// Controller: sequences execute, divide and result hand-off for each command beat.
module dost_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output dost_pkg::dost_cmd_t cmd,
	input  dost_pkg::dost_sts_t sts
);
	import dost_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_LOAD = 4'b0010,
		S_DIV  = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q, out_valid_d;
	logic   in_acc, out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	// result register frees up in the same cycle its beat is taken
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.exec     = in_acc;
		out_valid_d  = out_valid_q && !out_ready;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					state_d = S_LOAD;
				end
			end
			S_LOAD: begin
				cmd.div_load = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				if (sts.div_done) begin
					state_d = S_DONE;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					out_valid_d  = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	a_acc_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == S_LOAD)
		else $error("accepted beat did not start a division");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten while full");

	a_div_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && sts.div_done) |=> state_q == S_DONE)
		else $error("divider finished without result stage");

	a_exec_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> (!cmd.div_step && !cmd.div_load && !cmd.out_load))
		else $error("command executed during division");

endmodule

// ===== rtl/dual_output_safety_timer_core.sv =====
// Top level of the dual output safety timer.
// Each command beat passes from acceptance to result valid through a divider load,
// nine restoring-division steps for the analog code, a done check and a result load.
// A new command waits for the last result load; a pending result does not block it.
// The result register is the only buffer, so a stalled result holds the next one back.
// arst_n clears all channels, the target to the default level and the reference to 3300 mV.
module dual_output_safety_timer_core #(
	parameter int unsigned TEST_DURATION_MS = dost_pkg::TEST_MS_DEFAULT,
	parameter int unsigned DEFAULT_LEVEL_MV = dost_pkg::LEVEL_MV_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	dost_in_if.sink    cmd_in,
	dost_out_if.source res_out,
	input  logic       cfg_we,
	input  logic [11:0] cfg_wdata
);
	import dost_pkg::*;

	dost_cmd_t cmd;
	dost_sts_t sts;

	dost_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd_in.valid),
		.in_ready  (cmd_in.ready),
		.out_valid (res_out.valid),
		.out_ready (res_out.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	dost_dp #(
		.TEST_DURATION_MS (TEST_DURATION_MS),
		.DEFAULT_LEVEL_MV (DEFAULT_LEVEL_MV)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.opcode          (cmd_in.opcode),
		.channel         (cmd_in.channel),
		.value           (cmd_in.value),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.analog_enable   (res_out.analog_enable),
		.analog_code     (res_out.analog_code),
		.digital_high    (res_out.digital_high),
		.error_code      (res_out.error_code),
		.analog_release  (res_out.analog_release),
		.digital_release (res_out.digital_release),
		.timed_active    (res_out.timed_active),
		.any_active      (res_out.any_active)
	);

endmodule

// ===== tb/tb_dual_output_safety_timer_core.sv =====
// Self-checking testbench for the dual output safety timer core.
module tb_dual_output_safety_timer_core;
	import dost_pkg::*;

	localparam int unsigned TEST_MS  = TEST_MS_DEFAULT;
	localparam int unsigned LEVEL_MV = LEVEL_MV_DEFAULT;
	localparam logic [3:0] OP_FIRST_UNUSED = 4'd10;
	localparam logic [3:0] OP_LAST_CODE    = 4'd15;
	localparam int unsigned RANDOM_ITEMS   = 1450;
	localparam int unsigned RANDOM_PHASES  = 5;
	localparam int unsigned SETTLE_CYCLES  = 16;
	localparam int unsigned MAX_REPORTS    = 10;

	typedef struct packed {
		logic       analog_enable;
		logic [7:0] analog_code;
		logic       digital_high;
		err_t       error_code;
		rel_t       analog_release;
		rel_t       digital_release;
		logic       timed_active;
		logic       any_active;
	} timer_status_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [11:0] cfg_wdata;

	dost_in_if  cmd_if();
	dost_out_if res_if();

	dual_output_safety_timer_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_in    (cmd_if),
		.res_out   (res_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// predicted channel state
	logic        chan_on      [NUM_CH];
	logic        chan_testing [NUM_CH];
	logic [31:0] chan_ms      [NUM_CH];
	logic [31:0] chan_limit   [NUM_CH];
	logic [11:0] target_mv;
	logic [11:0] ref_mv;

	timer_status_t status_q [$];
	int unsigned   fail_count;
	int unsigned   src_gap_max;
	int unsigned   sink_gap_max;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic void restore_model();
		for (int i = 0; i < NUM_CH; i++) begin
			chan_on[i]      = 1'b0;
			chan_testing[i] = 1'b0;
			chan_ms[i]      = '0;
			chan_limit[i]   = '0;
		end
		target_mv = 12'(LEVEL_MV);
		ref_mv    = REF_RESET_MV;
	endfunction

	function automatic void switch_channel(int c, logic on);
		chan_testing[c] = 1'b0;
		chan_on[c]      = on;
		chan_ms[c]      = '0;
	endfunction

	function automatic void begin_test(int c);
		chan_on[c]      = 1'b1;
		chan_testing[c] = 1'b1;
		chan_ms[c]      = '0;
	endfunction

	// one millisecond on one channel; test end wins over the safety limit
	function automatic rel_t advance_channel(int c);
		if (chan_on[c] && chan_ms[c] != 32'hFFFF_FFFF)
			chan_ms[c] = chan_ms[c] + 32'd1;
		if (chan_testing[c]) begin
			if (chan_ms[c] >= TEST_MS) begin
				switch_channel(c, 1'b0);
				return REL_TEST;
			end
		end else if (chan_on[c] && chan_limit[c] != '0 && chan_ms[c] >= chan_limit[c]) begin
			switch_channel(c, 1'b0);
			return REL_TIMEOUT;
		end
		return REL_NONE;
	endfunction

	function automatic logic [7:0] level_code();
		int unsigned mv;
		int unsigned q;
		if (!chan_on[0])
			return 8'd0;
		mv = chan_testing[0] ? LEVEL_MV : 32'(target_mv);
		q  = (mv * 32'd255 + 32'(ref_mv) / 32'd2) / 32'(ref_mv);
		return (q > 32'd255) ? CODE_MAX : q[7:0];
	endfunction

	function automatic timer_status_t apply_command(logic [3:0] op, logic ch, logic [31:0] val);
		timer_status_t s;
		int c;
		s = '0;
		c = ch ? 1 : 0;
		case (op)
			OP_TICK: begin
				s.analog_release  = advance_channel(0);
				s.digital_release = advance_channel(1);
			end
			OP_ENABLE:  switch_channel(c, 1'b1);
			OP_DISABLE: switch_channel(c, 1'b0);
			OP_SET_MV: begin
				if (ch)
					s.error_code = ERR_DIGITAL;
				else if (val > 32'(ref_mv))
					s.error_code = ERR_RANGE;
				else begin
					if (chan_testing[0])
						switch_channel(0, 1'b0);
					target_mv = val[11:0];
					if (chan_on[0])
						chan_ms[0] = '0;
				end
			end
			OP_TEST: begin_test(c);
			OP_TIMEOUT: begin
				chan_limit[c] = val;
				if (chan_on[c] && !chan_testing[c])
					chan_ms[c] = '0;
			end
			OP_ALL_ON:   for (int i = 0; i < NUM_CH; i++) switch_channel(i, 1'b1);
			OP_ALL_OFF:  for (int i = 0; i < NUM_CH; i++) switch_channel(i, 1'b0);
			OP_ALL_TEST: for (int i = 0; i < NUM_CH; i++) begin_test(i);
			OP_DEFAULTS: restore_model();
			default: ;
		endcase
		s.analog_enable = chan_on[0];
		s.analog_code   = level_code();
		s.digital_high  = chan_on[1];
		s.timed_active  = (chan_on[0] && (chan_testing[0] || chan_limit[0] != '0)) ||
			(chan_on[1] && (chan_testing[1] || chan_limit[1] != '0));
		s.any_active    = chan_on[0] || chan_on[1];
		return s;
	endfunction

	function automatic string status_str(timer_status_t s);
		return $sformatf("en=%0d code=%0d dig=%0d err=%0d arel=%0d drel=%0d timed=%0d any=%0d",
			s.analog_enable, s.analog_code, s.digital_high, s.error_code,
			s.analog_release, s.digital_release, s.timed_active, s.any_active);
	endfunction

	task automatic send_cmd(logic [3:0] op, logic ch, logic [31:0] val);
		int unsigned gap;
		gap = $urandom_range(0, src_gap_max);
		@(negedge clk);
		if (gap > 0) begin
			cmd_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_if.valid   = 1'b1;
		cmd_if.opcode  = op;
		cmd_if.channel = ch;
		cmd_if.value   = val;
		do @(posedge clk); while (!cmd_if.ready);
		status_q.push_back(apply_command(op, ch, val));
	endtask

	// reference write, only once the block has nothing in flight
	task automatic write_ref(logic [11:0] v);
		@(negedge clk);
		cmd_if.valid = 1'b0;
		while (status_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		if (v >= REF_LOW_MV && v <= REF_HIGH_MV) begin
			ref_mv = v;
			if (target_mv > ref_mv)
				target_mv = ref_mv;
		end
	endtask

	task automatic test_directed_commands();
		src_gap_max  = 9;
		sink_gap_max = 9;
		send_cmd(OP_TICK, 1'b1, 32'hFFFF_FFFF);
		send_cmd(OP_SET_MV, 1'b1, 32'd100);
		send_cmd(OP_SET_MV, 1'b0, 32'd3301);
		send_cmd(OP_SET_MV, 1'b0, 32'hFFFF_FFFF);
		send_cmd(OP_SET_MV, 1'b0, 32'(REF_RESET_MV));
		send_cmd(OP_ENABLE, 1'b0, 32'd0);
		send_cmd(OP_SET_MV, 1'b0, 32'd0);
		send_cmd(OP_ENABLE, 1'b1, 32'h8000_0000);
		send_cmd(OP_TIMEOUT, 1'b1, 32'd3);
		repeat (3) send_cmd(OP_TICK, 1'b0, 32'd0);
		send_cmd(OP_TEST, 1'b0, 32'd0);
		// a new level while testing drops the analog channel
		send_cmd(OP_SET_MV, 1'b0, 32'd1000);
		send_cmd(OP_ALL_ON, 1'b0, 32'd0);
		send_cmd(OP_TIMEOUT, 1'b0, 32'hFFFF_FFFF);
		send_cmd(OP_TICK, 1'b0, 32'd0);
		send_cmd(OP_ALL_TEST, 1'b1, 32'd0);
		send_cmd(OP_ALL_OFF, 1'b0, 32'd0);
		send_cmd(OP_LAST_CODE, 1'b1, 32'hFFFF_FFFF);
		send_cmd(OP_FIRST_UNUSED, 1'b0, 32'd0);
		send_cmd(OP_DISABLE, 1'b1, 32'd0);
		send_cmd(OP_DEFAULTS, 1'b0, 32'd0);
		send_cmd(OP_TIMEOUT, 1'b0, 32'd1);
		send_cmd(OP_ENABLE, 1'b0, 32'd0);
		send_cmd(OP_TICK, 1'b0, 32'd0);
	endtask

	task automatic test_reference_config();
		write_ref(REF_LOW_MV - 12'd1);
		write_ref(REF_HIGH_MV + 12'd1);
		write_ref(12'd0);
		write_ref(12'hFFF);
		send_cmd(OP_SET_MV, 1'b0, 32'(REF_RESET_MV));
		send_cmd(OP_ENABLE, 1'b0, 32'd0);
		// target above the new reference gets clamped
		write_ref(REF_LOW_MV);
		send_cmd(OP_TICK, 1'b0, 32'd0);
		send_cmd(OP_SET_MV, 1'b0, 32'(REF_LOW_MV) + 32'd1);
		send_cmd(OP_SET_MV, 1'b0, 32'(REF_LOW_MV));
		write_ref(REF_HIGH_MV);
		send_cmd(OP_SET_MV, 1'b0, 32'(REF_HIGH_MV));
		send_cmd(OP_TEST, 1'b0, 32'd0);
		send_cmd(OP_SET_MV, 1'b0, 32'd1800);
		send_cmd(OP_ENABLE, 1'b0, 32'd0);
		send_cmd(OP_DEFAULTS, 1'b0, 32'd0);
		send_cmd(OP_ENABLE, 1'b0, 32'd0);
	endtask

	// full test run on both channels; a limit set during a test is ignored until it ends
	task automatic test_test_expiry();
		src_gap_max  = 0;
		sink_gap_max = 0;
		send_cmd(OP_ALL_TEST, 1'b0, 32'd0);
		send_cmd(OP_TIMEOUT, 1'b1, 32'd7);
		for (int unsigned i = 0; i < TEST_MS; i++) begin
			if (i == TEST_MS / 2) begin
				src_gap_max  = 9;
				sink_gap_max = 9;
			end
			send_cmd(OP_TICK, 1'(i), $urandom);
		end
		send_cmd(OP_ENABLE, 1'b1, 32'd0);
		repeat (7) send_cmd(OP_TICK, 1'b0, 32'd0);
		send_cmd(OP_DEFAULTS, 1'b0, 32'd0);
	endtask

	task automatic send_random_cmd();
		int unsigned pick;
		int unsigned sel;
		logic [3:0]  op;
		logic        ch;
		logic [31:0] val;
		pick = $urandom_range(0, 99);
		sel  = $urandom_range(0, 9);
		ch   = 1'($urandom_range(0, 1));
		val  = $urandom;
		if (pick < 48)
			op = OP_TICK;
		else if (pick < 55)
			op = OP_ENABLE;
		else if (pick < 60)
			op = OP_DISABLE;
		else if (pick < 69) begin
			op = OP_SET_MV;
			ch = ($urandom_range(0, 3) == 0);
			if (sel < 6)
				val = $urandom_range(0, 32'(ref_mv));
			else if (sel < 8)
				val = 32'(ref_mv) + 32'($urandom_range(0, 1));
		end else if (pick < 74)
			op = OP_TEST;
		else if (pick < 83) begin
			op = OP_TIMEOUT;
			if (sel < 8)
				val = $urandom_range(0, 24);
		end else if (pick < 87)
			op = OP_ALL_ON;
		else if (pick < 90)
			op = OP_ALL_OFF;
		else if (pick < 93)
			op = OP_ALL_TEST;
		else if (pick < 94)
			op = OP_DEFAULTS;
		else
			op = 4'($urandom_range(32'(OP_FIRST_UNUSED), 32'(OP_LAST_CODE)));
		send_cmd(op, ch, val);
	endtask

	task automatic test_random_traffic();
		for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: begin
					write_ref(REF_LOW_MV);
					src_gap_max  = 0;
					sink_gap_max = 0;
				end
				1: begin
					write_ref(REF_HIGH_MV);
					src_gap_max  = 9;
					sink_gap_max = 0;
				end
				2: begin
					write_ref(12'($urandom_range(32'(REF_LOW_MV), 32'(REF_HIGH_MV))));
					src_gap_max  = 0;
					sink_gap_max = 9;
				end
				3: begin
					// rejected write, reference stays put
					if ($urandom_range(0, 1) == 0)
						write_ref(12'($urandom_range(0, 32'(REF_LOW_MV) - 1)));
					else
						write_ref(12'($urandom_range(32'(REF_HIGH_MV) + 1, 32'hFFF)));
					src_gap_max  = 9;
					sink_gap_max = 9;
				end
				default: begin
					write_ref(12'($urandom_range(32'(REF_LOW_MV), 32'(REF_HIGH_MV))));
					src_gap_max  = 9;
					sink_gap_max = 9;
				end
			endcase
			repeat (RANDOM_ITEMS / RANDOM_PHASES) send_random_cmd();
		end
	endtask

	// result side: random stalls, every accepted beat checked against the oldest prediction
	initial begin
		int unsigned   gap;
		timer_status_t got;
		timer_status_t want;
		res_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			gap = $urandom_range(0, sink_gap_max);
			if (gap > 0) begin
				res_if.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			res_if.ready = 1'b1;
			do @(posedge clk); while (!res_if.valid);
			got.analog_enable   = res_if.analog_enable;
			got.analog_code     = res_if.analog_code;
			got.digital_high    = res_if.digital_high;
			got.error_code      = err_t'(res_if.error_code);
			got.analog_release  = rel_t'(res_if.analog_release);
			got.digital_release = rel_t'(res_if.digital_release);
			got.timed_active    = res_if.timed_active;
			got.any_active      = res_if.any_active;
			if (status_q.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("unexpected result beat: %s", status_str(got));
			end else begin
				want = status_q.pop_front();
				if (got.analog_enable !== want.analog_enable ||
						got.analog_code !== want.analog_code ||
						got.digital_high !== want.digital_high ||
						got.error_code !== want.error_code ||
						got.analog_release !== want.analog_release ||
						got.digital_release !== want.digital_release ||
						got.timed_active !== want.timed_active ||
						got.any_active !== want.any_active) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("mismatch at %0t\n  exp: %s\n  got: %s", $realtime,
							status_str(want), status_str(got));
				end
			end
			@(negedge clk);
		end
	end

	initial begin
		arst_n         = 1'b0;
		cmd_if.valid   = 1'b0;
		cmd_if.opcode  = 4'd0;
		cmd_if.channel = 1'b0;
		cmd_if.value   = 32'd0;
		cfg_we         = 1'b0;
		cfg_wdata      = 12'd0;
		fail_count     = 0;
		src_gap_max    = 9;
		sink_gap_max   = 9;
		restore_model();
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		test_directed_commands();
		test_reference_config();
		test_test_expiry();
		test_random_traffic();

		@(negedge clk);
		cmd_if.valid = 1'b0;
		while (status_q.size() != 0) @(posedge clk);
		repeat (4 * SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#8000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
